FILE: design/fss_pkg.sv
// ----------------------------------------------------------------------------
// Single-precision subtract package
// Shared command and status types for the controller and the datapath.
// ----------------------------------------------------------------------------
package fss_pkg;

  typedef struct packed {
    logic load;
    logic align;
    logic combine;
    logic norm;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic norm_done;
  } stat_t;

endpackage

FILE: design/fss_datapath.sv
// ----------------------------------------------------------------------------
// Single-precision subtract datapath
// Unpacks, aligns, adds or subtracts mantissas and normalizes one bit a cycle.
// ----------------------------------------------------------------------------
module fss_datapath (
  input  logic                 clk,
  input  logic [31:0]          minuend_bits,
  input  logic [31:0]          subtrahend_bits,
  input  fss_pkg::cmd_t        cmd,
  output fss_pkg::stat_t       stat,
  output logic [31:0]          result
);

  logic [31:0] f;
  logic [31:0] g;
  logic [24:0] mf;
  logic [24:0] mg;
  logic [24:0] mr;
  logic [7:0]  er;
  logic        sr;
  logic        f_zero;
  logic        g_zero;
  logic [7:0]  ef;
  logic [7:0]  eg;
  logic [7:0]  exp_gap;
  logic        f_small;

  assign ef = f[30:23];
  assign eg = g[30:23];
  assign f_zero = (ef == 8'd0) && (f[22:0] == 23'd0);
  assign g_zero = (eg == 8'd0) && (g[22:0] == 23'd0);
  assign f_small = ef < eg;
  assign exp_gap = f_small ? (eg - ef) : (ef - eg);

  assign stat.special = f_zero || g_zero;
  assign stat.norm_done = mr[23] || (mr == 25'd0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      f <= minuend_bits;
      g <= subtrahend_bits;
    end
    if (cmd.align) begin
      if (f_small) begin
        mf <= (exp_gap >= 8'd24) ? 25'd0 : ({2'b01, f[22:0]} >> exp_gap[4:0]);
        mg <= {2'b01, g[22:0]};
        er <= eg;
      end else begin
        mf <= {2'b01, f[22:0]};
        mg <= (exp_gap >= 8'd24) ? 25'd0 : ({2'b01, g[22:0]} >> exp_gap[4:0]);
        er <= ef;
      end
    end
    if (cmd.combine) begin
      if (f[31] != g[31]) begin
        sr <= f[31];
        if (mf[23:0] + mg[23:0] >= 25'h1000000) begin
          mr <= (mf + mg) >> 1;
          er <= er + 8'd1;
        end else begin
          mr <= mf + mg;
        end
      end else if (mf > mg) begin
        sr <= f[31];
        mr <= mf - mg;
      end else begin
        sr <= ~g[31];
        mr <= mg - mf;
      end
    end
    if (cmd.norm && !stat.norm_done) begin
      mr <= mr << 1;
      er <= er - 8'd1;
    end
    if (cmd.finish) begin
      if (f_zero) begin
        result <= g ^ 32'h80000000;
      end else if (g_zero) begin
        result <= f;
      end else if (mr == 25'd0) begin
        result <= 32'd0;
      end else begin
        result <= {sr, er, mr[22:0]};
      end
    end
  end

endmodule

FILE: design/fss_control.sv
// ----------------------------------------------------------------------------
// Single-precision subtract controller
// Sequences load, align, combine, normalize and finish steps.
// ----------------------------------------------------------------------------
module fss_control (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  fss_pkg::stat_t stat,
  output fss_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALIGN = 3'd1;
  localparam logic [2:0] S_COMB  = 3'd2;
  localparam logic [2:0] S_NORM  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.load = start;
        if (start) state_next = S_ALIGN;
      end
      S_ALIGN: begin
        cmd.align = 1'b1;
        state_next = stat.special ? S_FIN : S_COMB;
      end
      S_COMB: begin
        cmd.combine = 1'b1;
        state_next = S_NORM;
      end
      S_NORM: begin
        cmd.norm = 1'b1;
        if (stat.norm_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= cmd.finish;
    end
  end

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_FIN) else $error("done without finish");
  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("start not taken");
  a_norm_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_NORM && stat.norm_done) |=> state == S_FIN)
    else $error("normalize exit missed");

endmodule

FILE: design/float_single_subtract.sv
// ----------------------------------------------------------------------------
// Single-precision subtract, truncating
// Returns the IEEE single bit pattern of minuend minus subtrahend.
// ----------------------------------------------------------------------------
// channel   signals                              transfer
// input     start, minuend_bits, subtrahend_bits start high, busy low
// result    done, difference_bits                done high, one cycle
//
// When an operand is zero the combine and normalize steps are skipped;
// otherwise the normalize loop shifts the mantissa one bit per cycle.
// Reset returns the controller to idle; no item is in flight after it.
// The receiver cannot stall; each result shows for one cycle only.
// ----------------------------------------------------------------------------
module float_single_subtract (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] minuend_bits,
  input  logic [31:0] subtrahend_bits,
  output logic        done,
  output logic [31:0] difference_bits
);

  fss_pkg::cmd_t  cmd;
  fss_pkg::stat_t stat;

  fss_control u_control (
    .clk(clk), .rst(rst), .start(start), .stat(stat),
    .cmd(cmd), .busy(busy), .done(done)
  );

  fss_datapath u_datapath (
    .clk(clk), .minuend_bits(minuend_bits), .subtrahend_bits(subtrahend_bits),
    .cmd(cmd), .stat(stat), .result(difference_bits)
  );

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Single-precision subtract testbench
// Drives operand pairs through the command handshake with random idle gaps
// and compares every result strobe with a bit-exact truncating prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] minuend_bits = '0;
  logic [31:0] subtrahend_bits = '0;
  logic        done;
  logic [31:0] difference_bits;

  typedef struct packed {
    logic [31:0] f;
    logic [31:0] g;
  } pair_t;

  pair_t       pending_pairs[$];
  logic [31:0] expected_diffs[$];
  int          mismatches = 0;
  int          idle_pct = 0;

  float_single_subtract uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .minuend_bits(minuend_bits), .subtrahend_bits(subtrahend_bits),
    .done(done), .difference_bits(difference_bits)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] sub_truncated(logic [31:0] f, logic [31:0] g);
    logic        sf, sg, sr;
    logic [7:0]  ef, eg;
    logic [8:0]  exp_gap;
    logic [31:0] mf, mg, mr, er;
    sf = f[31];
    sg = g[31];
    ef = f[30:23];
    eg = g[30:23];
    if (ef == 0 && f[22:0] == 0) return g ^ 32'h8000_0000;
    if (eg == 0 && g[22:0] == 0) return f;
    mf = {8'd0, 1'b1, f[22:0]};
    mg = {8'd0, 1'b1, g[22:0]};
    if (ef < eg) begin
      exp_gap = 9'(eg - ef);
      mf = (exp_gap >= 24) ? 32'd0 : mf >> exp_gap;
      er = 32'(eg);
    end else begin
      exp_gap = 9'(ef - eg);
      mg = (exp_gap >= 24) ? 32'd0 : mg >> exp_gap;
      er = 32'(ef);
    end
    if (sf != sg) begin
      sr = sf;
      mr = mf + mg;
      if (mr[24]) begin
        mr = mr >> 1;
        er = er + 1;
      end
    end else begin
      if (mf > mg) begin
        sr = sf;
        mr = mf - mg;
      end else begin
        sr = ~sg;
        mr = mg - mf;
      end
      if (mr == 0) return 32'd0;
      for (int i = 0; i < 24 && !mr[23]; i++) begin
        mr = mr << 1;
        er = er - 1;
      end
    end
    return {sr, er[7:0], mr[22:0]};
  endfunction

  function automatic logic [31:0] random_float();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:0] = '0;
      1: v[30:23] = 8'($urandom_range(100, 154));
      2: v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      3: v[22:0] = $urandom_range(0, 1) ? 23'h7FFFFF : 23'h0;
      default: v[30:23] = 8'($urandom_range(110, 144));
    endcase
    return v;
  endfunction

  task automatic queue_pair(logic [31:0] f, logic [31:0] g);
    pending_pairs.push_back('{f: f, g: g});
  endtask

  // Random pairs, half with the subtrahend near the minuend, make cancellation and long normalization common.
  task automatic queue_random_pair();
    logic [31:0] f, g;
    f = random_float();
    g = random_float();
    case ($urandom_range(0, 5))
      0: g = {$urandom_range(0, 1) ? 1'b1 : 1'b0, f[30:0]};
      1: g = f ^ (32'd1 << $urandom_range(0, 22));
      2: g[30:23] = f[30:23] + 8'($urandom_range(0, 30)) - 8'd15;
      default: ;
    endcase
    queue_pair(f, g);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
    end else if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
      pair_t p;
      p = pending_pairs.pop_front();
      start <= 1'b1;
      minuend_bits <= p.f;
      subtrahend_bits <= p.g;
      expected_diffs.push_back(sub_truncated(p.f, p.g));
    end else begin
      start <= 1'b0;
      minuend_bits <= $urandom;
      subtrahend_bits <= $urandom;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_diffs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", difference_bits);
      end else begin
        logic [31:0] exp_d;
        exp_d = expected_diffs.pop_front();
        if (difference_bits !== exp_d) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", exp_d, difference_bits);
        end
      end
    end
  end

  initial begin
    int phase_idle[4] = '{0, 70, 0, 12};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    queue_pair(32'h0000_0000, 32'h3F80_0000);
    queue_pair(32'h8000_0000, 32'h8000_0000);
    queue_pair(32'h4040_0000, 32'h0000_0000);
    queue_pair(32'hC040_0000, 32'h8000_0000);
    queue_pair(32'h3F80_0000, 32'h3F80_0000);
    queue_pair(32'hBF80_0000, 32'hBF80_0000);
    queue_pair(32'h3F80_0000, 32'h3F80_0001);
    queue_pair(32'h3F80_0001, 32'h3F80_0000);
    queue_pair(32'h3F80_0000, 32'hBF80_0000);
    queue_pair(32'h3FFF_FFFF, 32'hBFFF_FFFF);
    queue_pair(32'h7F7F_FFFF, 32'hFF7F_FFFF);
    queue_pair(32'h4B80_0000, 32'h3F80_0000);
    queue_pair(32'h3F80_0000, 32'h4C00_0000);
    queue_pair(32'h0080_0000, 32'h0080_0001);
    queue_pair(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    queue_pair(32'h0000_0001, 32'h8000_0001);
    queue_pair(32'h7F80_0000, 32'h7FC0_0000);
    queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_pair(32'h4000_0000, 32'h3FFF_FFFF);
    queue_pair(32'h0000_0000, 32'h0000_0000);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      repeat (360) queue_random_pair();
      wait (pending_pairs.size() == 0);
    end
    @(posedge clk);
    wait (expected_diffs.size() == 0 && !busy);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_diffs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
